// ----- hw/rtl/fpfa_pkg.sv -----
`timescale 1ns / 1ps

package fpfa_pkg;

    localparam int unsigned FRAMES_DEF = 64;
    localparam int unsigned CFG_W      = 7;
    localparam int unsigned PID_W      = 16;
    localparam int unsigned PAGE_W     = 10;
    localparam int unsigned FNUM_W     = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_FREE     = 2'd0,
        ST_EVICT    = 2'd1,
        ST_RESIDENT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIFO_RD,
        S_TBL_RD
    } t_state;

    typedef struct packed {
        logic [PID_W-1:0]  process_id;
        logic [PAGE_W-1:0] page_number;
        logic              page_resident;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [FNUM_W-1:0] frame_number;
        logic [PID_W-1:0]  victim_process_id;
        logic [PAGE_W-1:0] victim_page_number;
    } t_rsp;

    // one frame table entry: current owner and page
    typedef struct packed {
        logic [PID_W-1:0]  owner;
        logic [PAGE_W-1:0] page;
    } t_entry;

endpackage

// ----- hw/rtl/fpfa_frame_tbl.sv -----
`timescale 1ns / 1ps

module fpfa_frame_tbl #(
    parameter int unsigned FRAMES = fpfa_pkg::FRAMES_DEF,
    localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic             i_clk,
    input  logic             i_re,
    input  logic [IW-1:0]    i_raddr,
    output fpfa_pkg::t_entry o_rdata,
    input  logic             i_we,
    input  logic [IW-1:0]    i_waddr,
    input  fpfa_pkg::t_entry i_wdata
);

    fpfa_pkg::t_entry mem [FRAMES];
    fpfa_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fpfa_fifo_mem.sv -----
`timescale 1ns / 1ps

module fpfa_fifo_mem #(
    parameter int unsigned FRAMES = fpfa_pkg::FRAMES_DEF,
    localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [IW-1:0] i_raddr,
    output logic [IW-1:0] o_rdata,
    input  logic          i_we,
    input  logic [IW-1:0] i_waddr,
    input  logic [IW-1:0] i_wdata
);

    logic [IW-1:0] mem [FRAMES];
    logic [IW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/fpfa_ctrl.sv -----
`timescale 1ns / 1ps

module fpfa_ctrl #(
    parameter int unsigned FRAMES = fpfa_pkg::FRAMES_DEF,
    localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int unsigned CW = $clog2(FRAMES + 1),
    localparam int unsigned LW = (CW > fpfa_pkg::CFG_W) ? CW : fpfa_pkg::CFG_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  fpfa_pkg::t_req               i_req,
    input  logic                         i_cfg_we,
    input  logic [fpfa_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                         o_fifo_re,
    output logic [IW-1:0]                o_fifo_raddr,
    input  logic [IW-1:0]                i_fifo_rdata,
    output logic                         o_fifo_we,
    output logic [IW-1:0]                o_fifo_waddr,
    output logic [IW-1:0]                o_fifo_wdata,
    output logic                         o_tbl_re,
    output logic [IW-1:0]                o_tbl_raddr,
    input  fpfa_pkg::t_entry             i_tbl_rdata,
    output logic                         o_tbl_we,
    output logic [IW-1:0]                o_tbl_waddr,
    output fpfa_pkg::t_entry             o_tbl_wdata,
    output logic                         o_done,
    output fpfa_pkg::t_rsp               o_rsp
);

    localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);
    localparam logic [LW-1:0] LIM_MAX  = LW'(FRAMES);
    localparam logic [LW-1:0] LIM_MIN  = LW'(1);

    fpfa_pkg::t_state r_state, n_state;
    logic [fpfa_pkg::CFG_W-1:0] r_cfg;
    // frames are only ever taken lowest first and never released, so the
    // valid frames always form the prefix [0, r_fill)
    logic [CW-1:0] r_fill, n_fill;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic          r_done, n_done;
    fpfa_pkg::t_req r_req;
    fpfa_pkg::t_rsp r_rsp, n_rsp;

    logic [LW-1:0] cfg_ext;
    logic [LW-1:0] fill_ext;
    logic [LW-1:0] limit;
    logic          accept;
    logic          has_free;
    logic [IW-1:0] fill_idx;
    logic [IW+fpfa_pkg::FNUM_W-1:0] fill_num;
    logic [IW+fpfa_pkg::FNUM_W-1:0] vict_num;

    assign cfg_ext  = LW'(r_cfg);
    assign fill_ext = LW'(r_fill);
    assign limit    = (cfg_ext == '0) ? LIM_MIN : ((cfg_ext > LIM_MAX) ? LIM_MAX : cfg_ext);
    assign has_free = fill_ext < limit;
    assign accept   = i_start && (r_state == fpfa_pkg::S_IDLE);
    assign fill_idx = r_fill[IW-1:0];
    assign fill_num = {{fpfa_pkg::FNUM_W{1'b0}}, fill_idx};
    assign vict_num = {{fpfa_pkg::FNUM_W{1'b0}}, i_fifo_rdata};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpfa_pkg::S_IDLE: begin
                if (accept && !i_req.page_resident && !has_free) begin
                    n_state = fpfa_pkg::S_FIFO_RD;
                end
            end
            fpfa_pkg::S_FIFO_RD: n_state = fpfa_pkg::S_TBL_RD;
            fpfa_pkg::S_TBL_RD:  n_state = fpfa_pkg::S_IDLE;
            default:             n_state = fpfa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_fifo_re    = 1'b0;
        o_fifo_raddr = r_head;
        o_fifo_we    = 1'b0;
        o_fifo_waddr = r_tail;
        o_fifo_wdata = fill_idx;
        o_tbl_re     = 1'b0;
        o_tbl_raddr  = i_fifo_rdata;
        o_tbl_we     = 1'b0;
        o_tbl_waddr  = fill_idx;
        o_tbl_wdata  = '{owner: i_req.process_id, page: i_req.page_number};
        n_fill       = r_fill;
        n_head       = r_head;
        n_tail       = r_tail;
        n_done       = 1'b0;
        n_rsp        = '{status: fpfa_pkg::ST_RESIDENT, default: '0};
        unique case (r_state)
            fpfa_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req.page_resident) begin
                        n_done = 1'b1;
                    end else if (has_free) begin
                        o_tbl_we  = 1'b1;
                        o_fifo_we = 1'b1;
                        n_fill    = r_fill + CW'(1);
                        n_tail    = (r_tail == LAST_IDX) ? '0 : r_tail + IW'(1);
                        n_done    = 1'b1;
                        n_rsp     = '{status: fpfa_pkg::ST_FREE,
                                      frame_number: fill_num[fpfa_pkg::FNUM_W-1:0],
                                      default: '0};
                    end else begin
                        o_fifo_re = 1'b1;
                    end
                end
            end
            fpfa_pkg::S_FIFO_RD: begin
                o_tbl_re = 1'b1;
            end
            fpfa_pkg::S_TBL_RD: begin
                // evict the oldest frame and requeue it at the tail
                o_tbl_we     = 1'b1;
                o_tbl_waddr  = i_fifo_rdata;
                o_tbl_wdata  = '{owner: r_req.process_id, page: r_req.page_number};
                o_fifo_we    = 1'b1;
                o_fifo_wdata = i_fifo_rdata;
                n_head       = (r_head == LAST_IDX) ? '0 : r_head + IW'(1);
                n_tail       = (r_tail == LAST_IDX) ? '0 : r_tail + IW'(1);
                n_done       = 1'b1;
                n_rsp        = '{status: fpfa_pkg::ST_EVICT,
                                 frame_number: vict_num[fpfa_pkg::FNUM_W-1:0],
                                 victim_process_id: i_tbl_rdata.owner,
                                 victim_page_number: i_tbl_rdata.page};
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpfa_pkg::S_IDLE;
            r_cfg   <= fpfa_pkg::CFG_RESET;
            r_fill  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
        if (accept) begin
            r_req <= i_req;
        end
    end

    assign o_busy = (r_state != fpfa_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ----- hw/rtl/fifo_page_frame_allocator_top.sv -----
`timescale 1ns / 1ps

// FIFO page frame allocator.
// Request channel: drive i_req and raise start; the item is taken at a rising
// edge where start is high and busy is low. Result channel: o_done is high for
// exactly one cycle with o_rsp valid; the receiver cannot stall it and must
// take the item in that cycle.
// Resident pages and loads into a free frame: result strobe in the cycle after
// acceptance, busy never rises, so a new item can follow every cycle.
// Evictions: the FIFO memory read, then the frame table read, then the write
// back, each memory read registered; busy is high through both reads and
// falls as the registered result strobe rises, so no new item is taken before it.
// Free frames are tracked with a fill count (frames are taken lowest first),
// so neither memory needs a clearing pass after reset.
// i_cfg_we writes frames_in_use (reset 64); write it only while idle.
// Reset (synchronous, active low) empties the FIFO, frees all frames and
// drops any item in flight; no result strobe follows it.
module fifo_page_frame_allocator_top #(
    parameter int unsigned FRAMES = fpfa_pkg::FRAMES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  fpfa_pkg::t_req             i_req,
    input  logic                       i_cfg_we,
    input  logic [fpfa_pkg::CFG_W-1:0] i_cfg_wdata,
    output logic                       o_done,
    output fpfa_pkg::t_rsp             o_rsp
);

    localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic             fifo_re;
    logic [IW-1:0]    fifo_raddr;
    logic [IW-1:0]    fifo_rdata;
    logic             fifo_we;
    logic [IW-1:0]    fifo_waddr;
    logic [IW-1:0]    fifo_wdata;
    logic             tbl_re;
    logic [IW-1:0]    tbl_raddr;
    fpfa_pkg::t_entry tbl_rdata;
    logic             tbl_we;
    logic [IW-1:0]    tbl_waddr;
    fpfa_pkg::t_entry tbl_wdata;

    fpfa_ctrl #(
        .FRAMES(FRAMES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_req        (i_req),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fifo_re    (fifo_re),
        .o_fifo_raddr (fifo_raddr),
        .i_fifo_rdata (fifo_rdata),
        .o_fifo_we    (fifo_we),
        .o_fifo_waddr (fifo_waddr),
        .o_fifo_wdata (fifo_wdata),
        .o_tbl_re     (tbl_re),
        .o_tbl_raddr  (tbl_raddr),
        .i_tbl_rdata  (tbl_rdata),
        .o_tbl_we     (tbl_we),
        .o_tbl_waddr  (tbl_waddr),
        .o_tbl_wdata  (tbl_wdata),
        .o_done       (o_done),
        .o_rsp        (o_rsp)
    );

    fpfa_fifo_mem #(
        .FRAMES(FRAMES)
    ) u_fifo_mem (
        .i_clk   (i_clk),
        .i_re    (fifo_re),
        .i_raddr (fifo_raddr),
        .o_rdata (fifo_rdata),
        .i_we    (fifo_we),
        .i_waddr (fifo_waddr),
        .i_wdata (fifo_wdata)
    );

    fpfa_frame_tbl #(
        .FRAMES(FRAMES)
    ) u_frame_tbl (
        .i_clk   (i_clk),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata)
    );

endmodule
